// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a condition implies a consequence on the same clock edge.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Check that a condition implies a consequence on the next clock edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- hw/rtl/kml2_pkg.sv -----
// Package: sizes, codes and types shared by the distance engine.
package kml2_pkg;
	localparam int unsigned MaxClusters  = 16;
	localparam int unsigned MaxFeatures  = 256;
	localparam int unsigned MaxColGroups = 8;
	localparam int unsigned ClW   = $clog2(MaxClusters);
	localparam int unsigned FtW   = $clog2(MaxFeatures);
	localparam int unsigned GrW   = $clog2(MaxColGroups);
	localparam int unsigned AddrW = ClW + FtW;
	localparam int unsigned Depth = MaxClusters * MaxFeatures;
	localparam int unsigned SumW  = 48;
	localparam int unsigned CntW  = 32;
	localparam int unsigned AccW  = 48;
	localparam int unsigned DistW = 40;
	localparam logic [3:0]  Unclustered = 4'd8;
	localparam logic [AccW-1:0] AccMax = {AccW{1'b1}};

	typedef enum logic [1:0] {
		ACT_BEGIN  = 2'd0,
		ACT_DIST   = 2'd1,
		ACT_ADD    = 2'd2,
		ACT_FINISH = 2'd3
	} action_t;

	localparam logic CfgBicluster = 1'b0;
	localparam logic CfgColGroups = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLEAR, ST_COPY_RD, ST_COPY_WR, ST_RD, ST_DIV, ST_SQ, ST_ACC,
		ST_ADD_WR, ST_ROOT, ST_ROOT_ACC, ST_MEAN, ST_OUT
	} state_t;

	// Control from the sequencer to the shared iterative unit.
	typedef struct packed {
		logic       start;
		logic       is_div;
		logic [6:0] steps;
	} iter_ctl_t;

	// Status back from the iterative unit.
	typedef struct packed {
		logic busy;
		logic done;
	} iter_sts_t;
endpackage

// ----- hw/rtl/kmeans_l2_distance_to_centroid.sv -----
// Top level: k-means distance and centroid update engine.
//
//  channel | dir | content
//  s_axis  | in  | tdata: action, cluster, feature, col_group, value; tlast: last
//  m_axis  | out | tdata: distance; tuser: empty_cluster
//  cfg     | in  | index 0 bicluster_mode, index 1 col_groups
//
// A distance element runs to the end before the next item is taken: the 64-step shared
// divide of sum by count (launch, 64 steps, done) plus read, square and accumulate;
// the divide is skipped when the count is zero. A plain row end adds a square root and
// an output step; a bicluster row end adds a root per group and a mean divide.
// Add elements read and then write the pending sum; begin clears the pending memory,
// finish copies it (not at all if nothing was added). Reset runs a clear of both
// memories first. The result register holds until taken; input stalls while full.
`include "assert_macros.svh"
module kmeans_l2_distance_to_centroid (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [1:0] action, [5:2] cluster, [13:6] feature, [17:14] col_group, [49:18] value
	input  logic [55:0] s_axis_tdata,
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [39:0] distance
	output logic [39:0] m_axis_tdata,
	// [0] empty_cluster
	output logic        m_axis_tuser,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data
);
	localparam int unsigned AW = kml2_pkg::AddrW;
	localparam int unsigned SW = kml2_pkg::SumW;
	localparam int unsigned GW = kml2_pkg::GrW;

	kml2_pkg::state_t state_q, state_d;
	logic              mode_q;
	logic [3:0]        groups_q;
	logic [GW:0]       eff_g;
	logic              added_q;
	logic              init_q;
	logic [AW-1:0]     ptr_q;
	logic              ptr_last;
	// latched item
	kml2_pkg::action_t act_q;
	logic [kml2_pkg::ClW-1:0] cl_q;
	logic [kml2_pkg::FtW-1:0] ft_q;
	logic [3:0]        grp_q;
	logic signed [31:0] val_q;
	logic              last_q;
	logic              take;
	// stores
	logic [kml2_pkg::CntW-1:0] ccnt_q [kml2_pkg::MaxClusters];
	logic [kml2_pkg::CntW-1:0] pcnt_q [kml2_pkg::MaxClusters];
	logic [kml2_pkg::AccW-1:0] row_q;
	logic [kml2_pkg::AccW-1:0] gacc_q [kml2_pkg::MaxColGroups];
	logic [GW:0]       gi_q;
	logic [kml2_pkg::AccW+GW:0] tot_q;
	// memories
	logic              c_we, p_we;
	logic [AW-1:0]     mem_addr;
	logic [SW-1:0]     c_wd, p_wd, c_rd, p_rd;
	// iterative unit
	kml2_pkg::iter_ctl_t ictl;
	kml2_pkg::iter_sts_t ists;
	logic [63:0]       ia;
	logic [31:0]       ib;
	logic [63:0]       ires;
	logic [SW-1:0]     mag;
	logic              neg_q;
	logic signed [49:0] diff_q;
	logic [48:0]       ad;
	logic [kml2_pkg::AccW-1:0] sq_q;
	logic [63:0]       prod;
	logic [kml2_pkg::AccW:0]   acc_sum;
	logic signed [SW:0] ssum;
	logic [SW-1:0]     ssat;
	logic [kml2_pkg::CntW-1:0] cnt_sel;
	logic              c_ok;
	logic              out_v_q;
	logic [39:0]       dist_q;
	logic              empty_q;
	logic              g_ok;

	assign take = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == kml2_pkg::ST_IDLE) && !out_v_q;
	assign ptr_last = (ptr_q == AW'(kml2_pkg::Depth - 1));
	assign eff_g = (groups_q == 4'd0) ? (GW+1)'(1) :
		(groups_q > 4'(kml2_pkg::MaxColGroups)) ? (GW+1)'(kml2_pkg::MaxColGroups) :
		(GW+1)'(groups_q);
	assign c_ok = 1'b1;
	assign cnt_sel = ccnt_q[cl_q];
	assign g_ok = (grp_q != kml2_pkg::Unclustered) && ({1'b0, grp_q} < 5'(eff_g));

	// Memories share one address: the sweep pointer or the item's row/column.
	assign mem_addr = (state_q == kml2_pkg::ST_CLEAR || state_q == kml2_pkg::ST_COPY_RD ||
		state_q == kml2_pkg::ST_COPY_WR) ? ptr_q : {cl_q, ft_q};

	kml2_ram #(.Width(SW), .Depth(kml2_pkg::Depth)) u_cent (
		.clk(clk), .we(c_we), .addr(mem_addr), .wdata(c_wd), .rdata(c_rd));
	kml2_ram #(.Width(SW), .Depth(kml2_pkg::Depth)) u_pend (
		.clk(clk), .we(p_we), .addr(mem_addr), .wdata(p_wd), .rdata(p_rd));

	kml2_iter u_iter (
		.clk(clk), .arst_n(arst_n), .ctl(ictl), .a(ia), .b(ib), .sts(ists), .res(ires));

	assign mag = c_rd[SW-1] ? (~c_rd + SW'(1)) : c_rd;
	assign ad = diff_q[49] ? 49'(-diff_q) : 49'(diff_q);
	assign prod = 64'(ad[31:0]) * 64'(ad[31:0]);
	assign ssum = {p_rd[SW-1], p_rd} + (SW+1)'(val_q);
	assign ssat = (ssum[SW] != ssum[SW-1]) ?
		(ssum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}}) : ssum[SW-1:0];

	always_comb begin
		acc_sum = '0;
		if (mode_q) begin
			acc_sum = {1'b0, gacc_q[grp_q[GW-1:0]]} + {1'b0, sq_q};
		end else begin
			acc_sum = {1'b0, row_q} + {1'b0, sq_q};
		end
	end

	// Sequencer: next state and unit control.
	always_comb begin
		state_d = state_q;
		ictl = '0;
		ia = '0;
		ib = '0;
		c_we = 1'b0;
		p_we = 1'b0;
		c_wd = p_rd;
		p_wd = '0;
		unique case (state_q)
			kml2_pkg::ST_CLEAR: begin
				// the centroid memory is cleared only by the pass after reset
				c_we = init_q;
				p_we = 1'b1;
				c_wd = '0;
				if (ptr_last) state_d = kml2_pkg::ST_IDLE;
			end
			kml2_pkg::ST_IDLE: begin
				if (take) begin
					unique case (kml2_pkg::action_t'(s_axis_tdata[1:0]))
						kml2_pkg::ACT_BEGIN:  state_d = kml2_pkg::ST_CLEAR;
						kml2_pkg::ACT_FINISH: state_d = added_q ? kml2_pkg::ST_COPY_RD :
							kml2_pkg::ST_IDLE;
						default: state_d = kml2_pkg::ST_RD;
					endcase
				end
			end
			kml2_pkg::ST_COPY_RD: state_d = kml2_pkg::ST_COPY_WR;
			kml2_pkg::ST_COPY_WR: begin
				c_we = 1'b1;
				state_d = ptr_last ? kml2_pkg::ST_IDLE : kml2_pkg::ST_COPY_RD;
			end
			kml2_pkg::ST_RD: begin
				if (act_q == kml2_pkg::ACT_ADD) begin
					state_d = kml2_pkg::ST_ADD_WR;
				end else if (cnt_sel != '0) begin
					state_d = kml2_pkg::ST_DIV;
				end else begin
					state_d = kml2_pkg::ST_SQ;
				end
			end
			kml2_pkg::ST_ADD_WR: begin
				p_we = 1'b1;
				p_wd = ssat;
				state_d = kml2_pkg::ST_IDLE;
			end
			kml2_pkg::ST_DIV: begin
				if (!ists.busy && !ists.done && !neg_q) begin
					ictl.start = 1'b1;
				end
				ia = {16'd0, mag};
				ib = cnt_sel;
				ictl.is_div = 1'b1;
				ictl.steps = 7'd64;
				if (ists.done) state_d = kml2_pkg::ST_SQ;
			end
			kml2_pkg::ST_SQ: state_d = kml2_pkg::ST_ACC;
			kml2_pkg::ST_ACC: begin
				if (!last_q) begin
					state_d = kml2_pkg::ST_IDLE;
				end else if (cnt_sel == '0) begin
					state_d = kml2_pkg::ST_OUT;
				end else begin
					state_d = kml2_pkg::ST_ROOT;
				end
			end
			kml2_pkg::ST_ROOT: begin
				if (!ists.busy && !ists.done && !neg_q) ictl.start = 1'b1;
				ia = mode_q ? {gacc_q[gi_q[GW-1:0]], 16'd0} : {row_q, 16'd0};
				ictl.steps = 7'd32;
				if (ists.done) state_d = mode_q ? kml2_pkg::ST_ROOT_ACC : kml2_pkg::ST_OUT;
			end
			kml2_pkg::ST_ROOT_ACC: begin
				state_d = (gi_q == eff_g - (GW+1)'(1)) ? kml2_pkg::ST_MEAN :
					kml2_pkg::ST_ROOT;
			end
			kml2_pkg::ST_MEAN: begin
				if (!ists.busy && !ists.done && !neg_q) ictl.start = 1'b1;
				ia = 64'(tot_q);
				ib = 32'(eff_g);
				ictl.is_div = 1'b1;
				ictl.steps = 7'd64;
				if (ists.done) state_d = kml2_pkg::ST_OUT;
			end
			kml2_pkg::ST_OUT: state_d = kml2_pkg::ST_IDLE;
			default: state_d = kml2_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kml2_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Control and small stores.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			groups_q <= 4'd1;
			added_q <= 1'b0;
			init_q  <= 1'b1;
			ptr_q   <= '0;
			out_v_q <= 1'b0;
			neg_q   <= 1'b0;
			gi_q    <= '0;
			row_q   <= '0;
			tot_q   <= '0;
			for (int i = 0; i < kml2_pkg::MaxClusters; i++) begin
				ccnt_q[i] <= '0;
				pcnt_q[i] <= '0;
			end
			for (int i = 0; i < kml2_pkg::MaxColGroups; i++) gacc_q[i] <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == kml2_pkg::CfgBicluster) mode_q <= cfg_data[0];
				else groups_q <= cfg_data;
			end
			if (m_axis_tvalid && m_axis_tready) out_v_q <= 1'b0;
			// neg_q marks that the unit has been launched in this state
			if (ictl.start) neg_q <= 1'b1;
			if (ists.done) neg_q <= 1'b0;
			unique case (state_q)
				kml2_pkg::ST_CLEAR, kml2_pkg::ST_COPY_WR: begin
					ptr_q <= ptr_last ? '0 : ptr_q + AW'(1);
					if (state_q == kml2_pkg::ST_CLEAR && ptr_last) init_q <= 1'b0;
				end
				kml2_pkg::ST_IDLE: begin
					if (take) begin
						unique case (kml2_pkg::action_t'(s_axis_tdata[1:0]))
							kml2_pkg::ACT_BEGIN: begin
								added_q <= 1'b0;
								row_q <= '0;
								for (int i = 0; i < kml2_pkg::MaxClusters; i++)
									pcnt_q[i] <= '0;
								for (int i = 0; i < kml2_pkg::MaxColGroups; i++)
									gacc_q[i] <= '0;
							end
							kml2_pkg::ACT_FINISH: begin
								if (added_q) ccnt_q <= pcnt_q;
							end
							kml2_pkg::ACT_ADD: begin
								added_q <= 1'b1;
								if (s_axis_tlast && pcnt_q[s_axis_tdata[5:2]] != '1)
									pcnt_q[s_axis_tdata[5:2]] <=
										pcnt_q[s_axis_tdata[5:2]] + 32'd1;
							end
							default: ;
						endcase
					end
				end
				kml2_pkg::ST_ACC: begin
					if (!mode_q) begin
						row_q <= acc_sum[kml2_pkg::AccW] ? kml2_pkg::AccMax :
							acc_sum[kml2_pkg::AccW-1:0];
					end else if (g_ok) begin
						gacc_q[grp_q[GW-1:0]] <= acc_sum[kml2_pkg::AccW] ?
							kml2_pkg::AccMax : acc_sum[kml2_pkg::AccW-1:0];
					end
					gi_q  <= '0;
					tot_q <= '0;
				end
				kml2_pkg::ST_ROOT_ACC: begin
					tot_q <= tot_q + (kml2_pkg::AccW+GW+1)'(ires[31:0]);
					gi_q  <= gi_q + (GW+1)'(1);
				end
				kml2_pkg::ST_OUT: begin
					out_v_q <= 1'b1;
					row_q <= '0;
					for (int i = 0; i < kml2_pkg::MaxColGroups; i++) gacc_q[i] <= '0;
				end
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (take) begin
			act_q  <= kml2_pkg::action_t'(s_axis_tdata[1:0]);
			cl_q   <= s_axis_tdata[5:2];
			ft_q   <= s_axis_tdata[13:6];
			grp_q  <= s_axis_tdata[17:14];
			val_q  <= s_axis_tdata[49:18];
			last_q <= s_axis_tlast;
		end
		if (state_q == kml2_pkg::ST_RD) begin
			diff_q <= 50'(val_q);
		end
		// the quotient reaches 2^47 at most, so 50 bits hold the difference
		if (state_q == kml2_pkg::ST_DIV && ists.done) begin
			diff_q <= c_rd[SW-1] ? 50'(val_q) + {1'b0, ires[48:0]} :
				50'(val_q) - {1'b0, ires[48:0]};
		end
		if (state_q == kml2_pkg::ST_SQ) begin
			sq_q <= (ad[48:32] != '0) ? kml2_pkg::AccMax : prod[63:16];
		end
		if (state_q == kml2_pkg::ST_ACC && cnt_sel == '0 && last_q) begin
			dist_q  <= '0;
			empty_q <= 1'b1;
		end
		if (state_q == kml2_pkg::ST_ROOT && ists.done && !mode_q) begin
			dist_q  <= ires[39:0];
			empty_q <= 1'b0;
		end
		if (state_q == kml2_pkg::ST_MEAN && ists.done) begin
			dist_q  <= ires[39:0];
			empty_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = dist_q;
	assign m_axis_tuser  = empty_q;

	// Hold the input off while busy, hold a waiting result, launch the unit only when idle.
	`ASSERT_IMPL(a_no_take_busy, clk, arst_n, state_q != kml2_pkg::ST_IDLE,
		!s_axis_tready)
	`ASSERT_NEXT(a_out_holds, clk, arst_n, out_v_q && !m_axis_tready, out_v_q)
	`ASSERT_IMPL(a_unit_once, clk, arst_n, ictl.start, !ists.busy && c_ok)
endmodule

// ----- hw/rtl/kml2_ram.sv -----
// Generic single-port RAM with registered read.
module kml2_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ----- hw/rtl/kml2_iter.sv -----
// Shared iterative unit: restoring division or integer square root, one bit a cycle.
module kml2_iter (
	input  logic              clk,
	input  logic              arst_n,
	input  kml2_pkg::iter_ctl_t ctl,
	input  logic [63:0]       a,
	input  logic [31:0]       b,
	output kml2_pkg::iter_sts_t sts,
	output logic [63:0]       res
);
	logic [63:0] x_q;
	logic [63:0] r_q;
	logic [65:0] rem_q;
	logic [31:0] d_q;
	logic [63:0] bit_q;
	logic        div_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [65:0] rem_sh;
	logic [65:0] trial;
	logic [64:0] rb;

	always_comb begin
		rem_sh = {rem_q[64:0], x_q[63]};
		trial  = rem_sh - {34'd0, d_q};
		rb     = {1'b0, r_q} + {1'b0, bit_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q   <= a;
			d_q   <= b;
			div_q <= ctl.is_div;
			r_q   <= '0;
			rem_q <= '0;
			bit_q <= 64'd1 << 62;
		end else if (busy_q) begin
			if (div_q) begin
				x_q <= {x_q[62:0], 1'b0};
				if (!trial[65]) begin
					rem_q <= trial;
					r_q   <= {r_q[62:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					r_q   <= {r_q[62:0], 1'b0};
				end
			end else begin
				if ({1'b0, x_q} >= rb) begin
					x_q <= x_q - rb[63:0];
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign res      = r_q;
endmodule

// ----- sim/kmeans_l2_distance_to_centroid_tb.sv -----
// Testbench for the k-means distance engine: directed and random streams checked against a predictor.
module kmeans_l2_distance_to_centroid_tb;
	import kml2_pkg::*;

	localparam int WatchdogLimit = 40000;
	// Begin and finish sweep the memories, so let them finish
	// before touching the configuration.
	localparam int SweepSettle   = 9000;
	localparam int LongHold      = 400;

	typedef struct packed {
		logic [DistW-1:0] distance;
		logic             empty;
	} dist_result_t;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [55:0]       s_axis_tdata;
	logic              s_axis_tlast;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [DistW-1:0]  m_axis_tdata;
	logic              m_axis_tuser;
	logic              cfg_we;
	logic              cfg_index;
	logic [3:0]        cfg_data;

	// Predictor state: centroid and pending stores, row accumulators, registers.
	longint            centroid_sum [Depth];
	longint            pending_sum  [Depth];
	int unsigned       centroid_cnt [MaxClusters];
	int unsigned       pending_cnt  [MaxClusters];
	logic [AccW-1:0]   row_acc;
	logic [AccW-1:0]   group_acc    [MaxColGroups];
	bit                added;
	bit                mode_bic;
	logic [3:0]        groups_reg;

	dist_result_t      expected_dist[$];
	int                errors;
	int                items_sent;
	int                idle_cycles;
	bit                no_idle;
	bit                long_hold_req;

	kmeans_l2_distance_to_centroid dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic [63:0] int_sqrt(logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		r = '0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [AccW-1:0] sat_add(logic [AccW-1:0] a, logic [AccW-1:0] b);
		logic [AccW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[AccW] ? AccMax : s[AccW-1:0];
	endfunction

	// Squared difference against the centroid, Q32.16, saturating.
	function automatic logic [AccW-1:0] sq_diff(int v, int c, int f);
		longint      mean;
		longint      s;
		longint      q;
		longint      d;
		logic [63:0] mag;
		logic [63:0] ad;
		mean = 0;
		if (centroid_cnt[c] != 0) begin
			s    = centroid_sum[c * MaxFeatures + f];
			mag  = s < 0 ? -s : s;
			q    = longint'(mag / 64'(centroid_cnt[c]));
			mean = s < 0 ? -q : q;
		end
		d  = longint'(v) - mean;
		ad = d < 0 ? -d : d;
		if (ad >= (64'd1 << 32)) return AccMax;
		return AccW'((ad * ad) >> 16);
	endfunction

	function automatic void clear_row();
		row_acc = '0;
		foreach (group_acc[i]) group_acc[i] = '0;
	endfunction

	// Advance the predictor by one accepted transaction.
	function automatic void predict_distance(action_t a, int c, int f, int g, int v, bit last);
		longint       s;
		int           ng;
		logic [63:0]  total;
		dist_result_t r;
		case (a)
			ACT_BEGIN: begin
				foreach (pending_sum[i]) pending_sum[i] = 0;
				foreach (pending_cnt[i]) pending_cnt[i] = 0;
				added = 1'b0;
				clear_row();
			end
			ACT_FINISH: begin
				if (added) begin
					centroid_sum = pending_sum;
					centroid_cnt = pending_cnt;
				end
			end
			ACT_ADD: begin
				added = 1'b1;
				s = pending_sum[c * MaxFeatures + f] + longint'(v);
				if (s > 64'sh7FFF_FFFF_FFFF) s = 64'sh7FFF_FFFF_FFFF;
				if (s < -64'sh8000_0000_0000) s = -64'sh8000_0000_0000;
				pending_sum[c * MaxFeatures + f] = s;
				if (last && pending_cnt[c] != 32'hFFFF_FFFF) pending_cnt[c]++;
			end
			default: begin
				ng = groups_reg == 0 ? 1 : (groups_reg > MaxColGroups ? MaxColGroups : groups_reg);
				if (mode_bic) begin
					if (g != Unclustered && g < ng)
						group_acc[g] = sat_add(group_acc[g], sq_diff(v, c, f));
				end else begin
					row_acc = sat_add(row_acc, sq_diff(v, c, f));
				end
				if (last) begin
					r = '0;
					if (centroid_cnt[c] == 0) begin
						r.empty = 1'b1;
					end else if (mode_bic) begin
						total = '0;
						for (int i = 0; i < ng; i++)
							total += int_sqrt({group_acc[i], 16'd0});
						r.distance = DistW'(total / ng);
					end else begin
						r.distance = DistW'(int_sqrt({row_acc, 16'd0}));
					end
					clear_row();
					expected_dist.push_back(r);
				end
			end
		endcase
	endfunction

	// ---------------------------------------------------------------- drivers

	// Offer one transaction; return once it is accepted, tvalid left high.
	task automatic send_item(action_t a, logic [3:0] c, logic [7:0] f, logic [3:0] g,
			logic [31:0] v, bit last);
		int gap;
		@(negedge clk);
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata  <= {6'd0, v, g, f, c, a};
		s_axis_tlast  <= last;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		predict_distance(a, c, f, g, v, last);
		items_sent++;
	endtask

	// Drain, let any sweep finish, then write both registers.
	task automatic set_config(bit bic, logic [3:0] grp);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_dist.size() != 0) @(negedge clk);
		repeat (SweepSettle) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CfgBicluster;
		cfg_data  <= {3'd0, bic};
		@(negedge clk);
		cfg_index <= CfgColGroups;
		cfg_data  <= grp;
		@(negedge clk);
		cfg_we    <= 1'b0;
		mode_bic   = bic;
		groups_reg = grp;
	endtask

	// Mostly small values so distances stay meaningful; sometimes any 32 bits.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 3))
			0:       return $urandom;
			1:       return 32'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
			default: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
		endcase
	endfunction

	task automatic add_row(logic [3:0] c, int len);
		for (int i = 0; i < len; i++)
			send_item(ACT_ADD, c, 8'($urandom_range(0, 7)), 4'($urandom_range(0, 8)),
				pick_value(), i == len - 1);
	endtask

	task automatic distance_row(logic [3:0] c, int len);
		for (int i = 0; i < len; i++)
			send_item(ACT_DIST, c, 8'($urandom_range(0, 7)), 4'($urandom_range(0, 9)),
				pick_value(), i == len - 1);
	endtask

	// ---------------------------------------------------------------- tests

	// Plain mode: iteration with extremes, empty cluster, finish with nothing added.
	task automatic test_plain_directed();
		set_config(1'b0, 4'd1);
		send_item(ACT_BEGIN,  0, 0, 0, 0, 1'b0);
		send_item(ACT_ADD,    0, 0,   0, 32'h7FFF_FFFF, 1'b0);
		send_item(ACT_ADD,    0, 255, 0, 32'h8000_0000, 1'b0);
		send_item(ACT_ADD,    0, 1,   0, 32'h0001_0000, 1'b1);
		send_item(ACT_ADD,    15, 2,  0, 32'hFFFF_0000, 1'b1);
		send_item(ACT_FINISH, 0, 0, 0, 0, 1'b0);
		send_item(ACT_DIST,   0, 0,   0, 32'h8000_0000, 1'b0);
		send_item(ACT_DIST,   0, 255, 0, 32'h7FFF_FFFF, 1'b0);
		send_item(ACT_DIST,   0, 1,   0, 32'h0002_0000, 1'b1);
		send_item(ACT_DIST,   15, 2,  0, 32'h0000_0001, 1'b1);
		// zero-count cluster mid-row, row judged on the last element's cluster
		send_item(ACT_DIST,   7, 1,   0, 32'h0003_0000, 1'b0);
		send_item(ACT_DIST,   0, 1,   0, 32'h0001_0000, 1'b1);
		send_item(ACT_DIST,   0, 1,   0, 32'h0001_0000, 1'b0);
		send_item(ACT_DIST,   9, 3,   0, 32'h0000_0000, 1'b1);
		// begin then finish with no add: centroids stay as they were
		send_item(ACT_BEGIN,  0, 0, 0, 0, 1'b0);
		send_item(ACT_FINISH, 0, 0, 0, 0, 1'b0);
		send_item(ACT_DIST,   0, 0,   0, 32'h0000_0000, 1'b1);
	endtask

	// Bicluster mode: unclustered and out-of-range groups, group count limits.
	task automatic test_bicluster_directed();
		set_config(1'b1, 4'd3);
		send_item(ACT_DIST, 0, 0, 0,  32'h0001_0000, 1'b0);
		send_item(ACT_DIST, 0, 1, 1,  32'hFFFE_0000, 1'b0);
		send_item(ACT_DIST, 0, 2, 8,  32'h7FFF_FFFF, 1'b0);
		send_item(ACT_DIST, 0, 3, 5,  32'h7FFF_FFFF, 1'b0);
		send_item(ACT_DIST, 0, 4, 15, 32'h8000_0000, 1'b0);
		send_item(ACT_DIST, 0, 5, 2,  32'h0004_0000, 1'b1);
		set_config(1'b1, 4'd0);
		send_item(ACT_DIST, 0, 0, 0,  32'h0005_0000, 1'b0);
		send_item(ACT_DIST, 0, 1, 1,  32'h0005_0000, 1'b1);
		set_config(1'b1, 4'd15);
		send_item(ACT_DIST, 0, 0, 7,  32'h0009_0000, 1'b0);
		send_item(ACT_DIST, 0, 1, 6,  32'h8000_0000, 1'b1);
	endtask

	// Mostly whole iterations with random content, the rest loose items.
	task automatic test_random(int n_items);
		int target;
		int k;
		target = items_sent + n_items;
		while (items_sent < target) begin
			if ($urandom_range(0, 9) < 6) begin
				send_item(ACT_BEGIN, 0, 0, 0, 0, 1'b0);
				k = $urandom_range(1, 4);
				repeat (k) add_row(4'($urandom_range(0, 3)), $urandom_range(1, 6));
				if ($urandom_range(0, 9) != 0) send_item(ACT_FINISH, 0, 0, 0, 0, 1'b0);
				k = $urandom_range(2, 6);
				repeat (k) distance_row(4'($urandom_range(0, 5)), $urandom_range(1, 6));
			end else begin
				k = $urandom_range(1, 4);
				repeat (k) begin
					case ($urandom_range(0, 19))
						0:       send_item(ACT_BEGIN, 4'($urandom), 8'($urandom),
								4'($urandom), $urandom, 1'($urandom));
						1:       send_item(ACT_FINISH, 4'($urandom), 8'($urandom),
								4'($urandom), $urandom, 1'($urandom));
						2, 3, 4, 5, 6, 7, 8:
							send_item(ACT_ADD, 4'($urandom), 8'($urandom),
								4'($urandom), $urandom, 1'($urandom));
						default: send_item(ACT_DIST, 4'($urandom), 8'($urandom),
								4'($urandom), $urandom, 1'($urandom));
					endcase
				end
			end
		end
	endtask

	// Hold the receiver off while short rows keep arriving, so the input stalls.
	task automatic test_backpressure();
		long_hold_req = 1'b1;
		repeat (6) distance_row(4'($urandom_range(0, 3)), 1);
		test_random(40);
	endtask

	// ---------------------------------------------------------------- result side

	initial begin
		int gap;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				gap = LongHold;
				long_hold_req = 1'b0;
			end else begin
				gap = no_idle ? 0 : $urandom_range(0, 9);
			end
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// Compare each result transaction with the oldest expectation.
	always @(posedge clk) begin
		dist_result_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_dist.size() == 0) begin
				$display("%0t: unexpected result distance=%h empty=%b", $time,
					m_axis_tdata, m_axis_tuser);
				errors++;
			end else begin
				exp_r = expected_dist.pop_front();
				if (m_axis_tdata !== exp_r.distance) begin
					$display("%0t: distance expected %h actual %h", $time,
						exp_r.distance, m_axis_tdata);
					errors++;
				end
				if (m_axis_tuser !== exp_r.empty) begin
					$display("%0t: empty_cluster expected %b actual %b", $time,
						exp_r.empty, m_axis_tuser);
					errors++;
				end
			end
		end
	end

	// Watchdog: count cycles in which neither side moves a transaction and no configuration is written.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WatchdogLimit) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		errors        = 0;
		items_sent    = 0;
		idle_cycles   = 0;
		no_idle       = 1'b0;
		long_hold_req = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CfgBicluster;
		cfg_data      = '0;
		foreach (centroid_sum[i]) begin
			centroid_sum[i] = 0;
			pending_sum[i]  = 0;
		end
		foreach (centroid_cnt[i]) begin
			centroid_cnt[i] = 0;
			pending_cnt[i]  = 0;
		end
		clear_row();
		added      = 1'b0;
		mode_bic   = 1'b0;
		groups_reg = 4'd1;
		arst_n     = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_plain_directed();
		test_bicluster_directed();
		set_config(1'b0, 4'd1);
		test_random(100);
		set_config(1'b1, 4'd1);
		test_random(80);
		set_config(1'b1, 4'd8);
		test_random(90);
		set_config(1'b0, 4'd4);
		no_idle = 1'b1;
		test_random(60);
		no_idle = 1'b0;
		test_backpressure();
		set_config(1'b1, 4'($urandom_range(2, 7)));
		test_random(90);
		set_config(1'b1, 4'd15);
		test_random(50);

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_dist.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
